// ===== hw/rtl/les_pkg.sv =====
// Package for the line editor keyword LED select unit.
// Holds widths, character codes and the keyword tables; no dependencies.
`timescale 1ns / 1ps

package les_pkg;

   localparam int LINE_DEPTH  = 64;
   localparam int ADDR_W      = $clog2(LINE_DEPTH);
   localparam int IDX_W       = $clog2(LINE_DEPTH + 1);
   localparam int LIMIT_W     = 7;
   localparam int CMP_W       = (IDX_W > LIMIT_W) ? IDX_W : LIMIT_W;
   localparam int KEY_COUNT   = 7;
   localparam int KEY_LEN_W   = 3;
   localparam int LED_W       = 4;

   localparam logic [7:0] CHAR_DEL = 8'h7F;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;

   typedef logic [KEY_COUNT-1:0] key_mask_type;

   function automatic logic [7:0] fold_lower(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

   // Keyword order: red, blue, green, pink, yellow, cyan, white.
   function automatic logic [KEY_LEN_W-1:0] key_len(input int k);
      logic [KEY_LEN_W-1:0] r;
      case (k)
         0: r = 3'd3;
         1: r = 3'd4;
         2: r = 3'd5;
         3: r = 3'd4;
         4: r = 3'd6;
         5: r = 3'd4;
         6: r = 3'd5;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [LED_W-1:0] key_led(input int k);
      logic [LED_W-1:0] r;
      case (k)
         0: r = 4'h2;
         1: r = 4'h4;
         2: r = 4'h8;
         3: r = 4'h6;
         4: r = 4'hA;
         5: r = 4'hC;
         6: r = 4'hE;
         default: r = 4'h0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] key_char(input int k, input logic [2:0] i);
      logic [47:0] txt;
      logic [7:0]  r;
      case (k)
         0: txt = {8'h00, 8'h00, 8'h00, "der"};
         1: txt = {8'h00, 8'h00, "eulb"};
         2: txt = {8'h00, "neerg"};
         3: txt = {8'h00, 8'h00, "knip"};
         4: txt = "wolley";
         5: txt = {8'h00, 8'h00, "nayc"};
         6: txt = {8'h00, "etihw"};
         default: txt = '0;
      endcase
      case (i)
         3'd0: r = txt[7:0];
         3'd1: r = txt[15:8];
         3'd2: r = txt[23:16];
         3'd3: r = txt[31:24];
         3'd4: r = txt[39:32];
         3'd5: r = txt[47:40];
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/les_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module les_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/line_editor_keyword_led_select_unit.sv =====
// Line editor with keyword LED select: top level.
// A plain byte goes from IDLE through EMIT1 into the result register; a line end first
// runs the keyword compare through RD and CK for each compared byte, at most 6 of them.
// The input stays stalled from each transaction until its last result is loaded, and at
// a line end also through the byte-serial compare on the line store's single read port.
// Reset (synchronous, active high) clears the write index, LEDs and sets the limit to 64.
`timescale 1ns / 1ps

module line_editor_keyword_led_select_unit (
   input  logic                          clock,
   input  logic                          reset,
   // Input channel.
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_rx_char,
   // Result channel.
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_echo_byte,
   output logic                          rsp_last_of_run,
   output logic                          rsp_line_done,
   output logic [les_pkg::LED_W-1:0]     rsp_led_pattern,
   // Configuration write channel.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [les_pkg::LIMIT_W-1:0]   csr_line_limit
);

   // Sequencer states. IDLE takes a transaction; RD presents a line store address;
   // CK compares the returned byte against every keyword at once; EMIT1 and EMIT2
   // load the result register as soon as it is free.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RD    = 3'd1;
   localparam logic [2:0] ST_CK    = 3'd2;
   localparam logic [2:0] ST_EMIT1 = 3'd3;
   localparam logic [2:0] ST_EMIT2 = 3'd4;

   localparam int IDX_W = les_pkg::IDX_W;
   localparam int CMP_W = les_pkg::CMP_W;

   logic [2:0]                       state_ff, state_in;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic [IDX_W-1:0]                 len_ff, len_in;
   logic [IDX_W-1:0]                 cnt_ff, cnt_in;
   les_pkg::key_mask_type            miss_ff, miss_in;
   logic [les_pkg::LED_W-1:0]        led_ff, led_in;
   logic [les_pkg::LIMIT_W-1:0]      limit_ff, limit_in;
   logic [7:0]                       char_ff, char_in;
   logic                             done_ff, done_in;

   // Result register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [7:0]                       echo_ff, echo_in;
   logic                             last_ff, last_in;
   logic                             ldone_ff, ldone_in;
   logic [les_pkg::LED_W-1:0]        rled_ff, rled_in;

   logic                             accept;
   logic                             slot_free;
   logic [CMP_W-1:0]                 lim;
   logic [CMP_W-1:0]                 new_idx;
   logic                             ram_we;
   logic [les_pkg::ADDR_W-1:0]       ram_rd_addr;
   logic [7:0]                       ram_rd_data;
   logic [7:0]                       folded;
   logic [les_pkg::LED_W-1:0]        match_led;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // The effective limit is clamped to the range 2 to the store depth.
   always_comb begin
      if (CMP_W'(limit_ff) < CMP_W'(2)) begin
         lim = CMP_W'(2);
      end else if (CMP_W'(limit_ff) > CMP_W'(les_pkg::LINE_DEPTH)) begin
         lim = CMP_W'(les_pkg::LINE_DEPTH);
      end else begin
         lim = CMP_W'(limit_ff);
      end
   end

   // A plain byte is written at the write index while the store has room.
   assign ram_we  = accept && (req_rx_char != les_pkg::CHAR_DEL)
                    && (req_rx_char != les_pkg::CHAR_LF)
                    && (req_rx_char != les_pkg::CHAR_CR)
                    && (CMP_W'(idx_ff) < CMP_W'(les_pkg::LINE_DEPTH));
   assign new_idx = ram_we ? CMP_W'(idx_ff) + CMP_W'(1) : CMP_W'(idx_ff);

   assign ram_rd_addr = cnt_ff[les_pkg::ADDR_W-1:0];

   les_ram #(
      .WIDTH(8),
      .DEPTH(les_pkg::LINE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff[les_pkg::ADDR_W-1:0]),
      .wr_data (req_rx_char),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign folded = les_pkg::fold_lower(ram_rd_data);

   // The first keyword still standing wins; the keywords never collide anyway.
   always_comb begin
      match_led = '0;
      for (int k = les_pkg::KEY_COUNT - 1; k >= 0; k--) begin
         if (!miss_ff[k]) begin
            match_led = les_pkg::key_led(k);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      miss_in      = miss_ff;
      led_in       = led_ff;
      limit_in     = limit_ff;
      char_in      = char_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      echo_in      = echo_ff;
      last_in      = last_ff;
      ldone_in     = ldone_ff;
      rled_in      = rled_ff;

      if (csr_valid && csr_ready) begin
         limit_in = csr_line_limit;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               char_in  = req_rx_char;
               state_in = ST_EMIT1;
               done_in  = 1'b0;
               if (req_rx_char == les_pkg::CHAR_DEL) begin
                  if (idx_ff != '0) begin
                     idx_in = idx_ff - IDX_W'(1);
                  end
               end else if (req_rx_char == les_pkg::CHAR_LF
                            || req_rx_char == les_pkg::CHAR_CR) begin
                  done_in = 1'b1;
               end else begin
                  idx_in = IDX_W'(new_idx);
                  if (new_idx >= lim - CMP_W'(1)) begin
                     done_in = 1'b1;
                  end
               end
               if (done_in) begin
                  // Start the compare over the finished line; only keywords of the
                  // same length stay candidates.
                  len_in   = IDX_W'(new_idx);
                  cnt_in   = '0;
                  idx_in   = '0;
                  state_in = ST_RD;
                  for (int k = 0; k < les_pkg::KEY_COUNT; k++) begin
                     miss_in[k] = (new_idx != CMP_W'(les_pkg::key_len(k)));
                  end
               end
            end
         end
         ST_RD: begin
            if (cnt_ff == len_ff || (&miss_ff)) begin
               led_in   = match_led;
               state_in = ST_EMIT1;
            end else begin
               state_in = ST_CK;
            end
         end
         ST_CK: begin
            for (int k = 0; k < les_pkg::KEY_COUNT; k++) begin
               if (folded != les_pkg::key_char(k, cnt_ff[2:0])) begin
                  miss_in[k] = 1'b1;
               end
            end
            cnt_in   = cnt_ff + IDX_W'(1);
            state_in = ST_RD;
         end
         ST_EMIT1: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               ldone_in     = done_ff;
               rled_in      = led_ff;
               if (char_ff == les_pkg::CHAR_LF) begin
                  // A line feed goes out as carriage return, then line feed.
                  echo_in  = les_pkg::CHAR_CR;
                  last_in  = 1'b0;
                  state_in = ST_EMIT2;
               end else begin
                  echo_in  = char_ff;
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT2: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               echo_in      = les_pkg::CHAR_LF;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         led_ff       <= '0;
         limit_ff     <= les_pkg::LIMIT_W'(64);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         led_ff       <= led_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      cnt_ff   <= cnt_in;
      miss_ff  <= miss_in;
      char_ff  <= char_in;
      done_ff  <= done_in;
      echo_ff  <= echo_in;
      last_ff  <= last_in;
      ldone_ff <= ldone_in;
      rled_ff  <= rled_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_echo_byte   = echo_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_line_done   = ldone_ff;
   assign rsp_led_pattern = rled_ff;

endmodule

// ===== hw/rtl/les_checker.sv =====
// Port-level checker for the line editor keyword LED select unit, with its bind.
// Depends on les_pkg and the top level's ports.
`timescale 1ns / 1ps

module les_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [7:0]                 rsp_echo_byte,
   input logic                       rsp_last_of_run,
   input logic [les_pkg::LED_W-1:0]  rsp_led_pattern
);

   // A held result keeps its byte.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_echo_byte))
      else $error("result changed while stalled");

   // The carriage return of a line feed is followed at once by the line feed.
   a_lf_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run
      |=> rsp_valid && rsp_last_of_run && rsp_echo_byte == les_pkg::CHAR_LF)
      else $error("line feed did not follow carriage return");

   // Only an inserted carriage return is not the last result of its transaction.
   a_first_is_cr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> rsp_echo_byte == les_pkg::CHAR_CR)
      else $error("non-final result is not a carriage return");

   // No keyword pattern drives the lowest LED bit.
   a_led_bit0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_led_pattern[0])
      else $error("LED bit 0 set");

   // The block is busy in the cycle after it takes a transaction.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after a transaction");

endmodule

bind line_editor_keyword_led_select_unit les_checker u_les_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_echo_byte   (rsp_echo_byte),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_led_pattern (rsp_led_pattern)
);

// ===== bench/tb.sv =====
// Self-checking testbench for line_editor_keyword_led_select_unit.
// Depends on les_pkg and the unit itself; contains a small scoreboard class and driver tasks.
`timescale 1ns / 1ps

module tb;

   // Watchdog: cycles in a row with no transaction on any channel before the run is declared hung.
   // The longest legal quiet spell is a sender gap plus a line-end compare plus a receiver stall,
   // and this limit leaves a wide margin over it.
   localparam int WATCHDOG_LIMIT = 2000;
   // Extra cycles after the last expected result, to catch any stray result.
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_ITEMS   = 2000;

   localparam logic [les_pkg::LED_W-1:0] LED_RED    = 4'h2;
   localparam logic [les_pkg::LED_W-1:0] LED_BLUE   = 4'h4;
   localparam logic [les_pkg::LED_W-1:0] LED_GREEN  = 4'h8;
   localparam logic [les_pkg::LED_W-1:0] LED_PINK   = 4'h6;
   localparam logic [les_pkg::LED_W-1:0] LED_YELLOW = 4'hA;
   localparam logic [les_pkg::LED_W-1:0] LED_CYAN   = 4'hC;
   localparam logic [les_pkg::LED_W-1:0] LED_WHITE  = 4'hE;
   localparam logic [les_pkg::LED_W-1:0] LED_DARK   = 4'h0;

   // One result transaction as the unit should present it.
   typedef struct packed {
      logic [7:0]                echo_byte;
      logic                      last_of_run;
      logic                      line_done;
      logic [les_pkg::LED_W-1:0] led_pattern;
   } echo_result_type;

   // The scoreboard keeps its own copy of the line buffer, the fill count, the LED state
   // and the limit register. Every accepted character is turned into the results it must
   // produce, and every accepted result is compared against the oldest of those.
   class led_line_scoreboard;
      string                       color_words [7];
      logic [les_pkg::LED_W-1:0]   color_leds [7];
      logic [7:0]                  line_buf [les_pkg::LINE_DEPTH];
      int unsigned                 fill;
      logic [les_pkg::LED_W-1:0]   led_state;
      logic [les_pkg::LIMIT_W-1:0] limit_reg;
      echo_result_type             expected_q [$];
      int                          errors;

      function new();
         color_words = '{"red", "blue", "green", "pink", "yellow", "cyan", "white"};
         color_leds  = '{LED_RED, LED_BLUE, LED_GREEN, LED_PINK, LED_YELLOW, LED_CYAN,
                         LED_WHITE};
         fill      = 0;
         led_state = LED_DARK;
         limit_reg = 7'd64;
         errors    = 0;
      endfunction

      function automatic logic [7:0] to_lower(logic [7:0] b);
         if (b >= 8'h41 && b <= 8'h5A) begin
            return b + 8'h20;
         end
         return b;
      endfunction

      // LED code for the buffered line, or dark when no color word matches exactly.
      function automatic logic [les_pkg::LED_W-1:0] keyword_led();
         bit same;
         for (int k = 0; k < 7; k++) begin
            if (fill != color_words[k].len()) begin
               continue;
            end
            same = 1'b1;
            for (int i = 0; i < fill; i++) begin
               if (to_lower(line_buf[i]) != color_words[k][i]) begin
                  same = 1'b0;
               end
            end
            if (same) begin
               return color_leds[k];
            end
         end
         return LED_DARK;
      endfunction

      function void set_limit(logic [les_pkg::LIMIT_W-1:0] v);
         limit_reg = v;
      endfunction

      function void note_char(logic [7:0] c);
         int unsigned     lim;
         bit              ends;
         echo_result_type r;
         lim = 32'(limit_reg);
         if (lim < 2) begin
            lim = 2;
         end
         if (lim > les_pkg::LINE_DEPTH) begin
            lim = les_pkg::LINE_DEPTH;
         end
         ends = 1'b0;
         if (c == les_pkg::CHAR_DEL) begin
            if (fill > 0) begin
               fill--;
            end
         end else if (c == les_pkg::CHAR_LF || c == les_pkg::CHAR_CR) begin
            ends = 1'b1;
         end else begin
            if (fill < les_pkg::LINE_DEPTH) begin
               line_buf[fill] = c;
               fill++;
            end
            // Also covers a limit that was lowered below the current fill.
            if (fill >= lim - 1) begin
               ends = 1'b1;
            end
         end
         if (ends) begin
            led_state = keyword_led();
            fill = 0;
         end
         r.line_done   = ends;
         r.led_pattern = led_state;
         if (c == les_pkg::CHAR_LF) begin
            r.echo_byte   = les_pkg::CHAR_CR;
            r.last_of_run = 1'b0;
            expected_q.push_back(r);
         end
         r.echo_byte   = c;
         r.last_of_run = 1'b1;
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [7:0] echo, logic last, logic done,
                                 logic [les_pkg::LED_W-1:0] led);
         echo_result_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected result transaction: echo_byte %02h", echo);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (echo !== e.echo_byte) begin
            $error("echo_byte: expected %02h, got %02h", e.echo_byte, echo);
            errors++;
         end
         if (last !== e.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", e.last_of_run, last);
            errors++;
         end
         if (done !== e.line_done) begin
            $error("line_done: expected %0b, got %0b", e.line_done, done);
            errors++;
         end
         if (led !== e.led_pattern) begin
            $error("led_pattern: expected %0h, got %0h", e.led_pattern, led);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [7:0]                  req_rx_char;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [7:0]                  rsp_echo_byte;
   logic                        rsp_last_of_run;
   logic                        rsp_line_done;
   logic [les_pkg::LED_W-1:0]   rsp_led_pattern;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [les_pkg::LIMIT_W-1:0] csr_line_limit;

   led_line_scoreboard book;
   int                 items_sent;
   int                 stall_hold;
   bit                 quiet_phase;

   line_editor_keyword_led_select_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_char     (req_rx_char),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_echo_byte   (rsp_echo_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_line_done   (rsp_line_done),
      .rsp_led_pattern (rsp_led_pattern),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_line_limit  (csr_line_limit)
   );

   always #2 clock = ~clock;

   // Idle length used by both sides: mostly short, now and then long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return $urandom_range(1, 3);
      end else if (r < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Gap before the next input transaction. A quiet phase sends back to back.
   function automatic int pick_gap();
      if (quiet_phase || $urandom_range(0, 99) < 45) begin
         return 0;
      end
      return idle_length();
   endfunction

   // All channel activity is sampled at the rising edge, before the unit's own
   // registers update, so the scoreboard sees exactly what crossed each handshake.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            book.set_limit(csr_line_limit);
         end
         if (req_valid && !req_stall) begin
            book.note_char(req_rx_char);
         end
         if (rsp_valid && !rsp_stall) begin
            book.check_result(rsp_echo_byte, rsp_last_of_run, rsp_line_done, rsp_led_pattern);
         end
      end
   end

   // The result side alternates between stall bursts and free stretches. Some free
   // stretches are long so that the unit also runs at full rate.
   always @(negedge clock) begin
      if (stall_hold != 0) begin
         stall_hold--;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                  : $urandom_range(0, 8);
      end else begin
         rsp_stall <= 1'b1;
         stall_hold = idle_length() - 1;
      end
   end

   // The run is declared hung when no transaction of any kind completes for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready) || reset) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("tb: done, errors");
      $finish;
   end

   // Every driver task is entered and left at a falling edge. The valid stays high when the
   // next character follows with no gap, so it is never lowered and raised in one step.
   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_char <= c;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i]);
      end
   endtask

   // The limit is only changed while nothing is in flight.
   task automatic write_limit(input logic [les_pkg::LIMIT_W-1:0] v);
      req_valid <= 1'b0;
      while (book.pending() != 0) @(negedge clock);
      csr_valid      <= 1'b1;
      csr_line_limit <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_terminator();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) begin
         send_char(les_pkg::CHAR_LF);
      end else if (r < 9) begin
         send_char(les_pkg::CHAR_CR);
      end
   endtask

   // A color word in random letter case, sometimes with a typo that is erased by DEL.
   task automatic send_keyword_line();
      int         k;
      int         typo_at;
      string      w;
      logic [7:0] ch;
      k = $urandom_range(0, 6);
      w = book.color_words[k];
      typo_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, w.len() - 1)) : -1;
      for (int i = 0; i < w.len(); i++) begin
         if (i == typo_at) begin
            send_char(8'($urandom_range(8'h21, 8'h7E)));
            send_char(les_pkg::CHAR_DEL);
         end
         ch = w[i];
         if ($urandom_range(0, 1) == 1) begin
            ch = ch - 8'h20;
         end
         send_char(ch);
      end
      send_terminator();
   endtask

   // A color word that is off by one character, one too short or one too long.
   task automatic send_near_miss();
      int         k;
      int         j;
      int         mode;
      string      w;
      logic [7:0] odd;
      logic [7:0] edges [4];
      edges = '{8'h40, 8'h5B, 8'h60, 8'h7B};
      k = $urandom_range(0, 6);
      w = book.color_words[k];
      mode = $urandom_range(0, 2);
      j = $urandom_range(0, w.len() - 1);
      // Bytes just outside the letter ranges check the case folding boundaries.
      odd = ($urandom_range(0, 1) == 1) ? edges[$urandom_range(0, 3)]
                                        : 8'($urandom_range(0, 255));
      for (int i = 0; i < w.len(); i++) begin
         if (mode == 0 && i == j) begin
            send_char(odd);
         end else if (!(mode == 1 && i == w.len() - 1)) begin
            send_char(w[i]);
         end
      end
      if (mode == 2) begin
         send_char(8'($urandom_range(8'h61, 8'h7A)));
      end
      send_terminator();
   endtask

   // Arbitrary bytes, long enough at times to run into the line limit.
   task automatic send_noise();
      int n;
      n = $urandom_range(1, 70);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            send_char(8'($urandom_range(8'h61, 8'h7A)));
         end else begin
            send_char(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      logic [les_pkg::LIMIT_W-1:0] first_limits [7];
      logic [les_pkg::LIMIT_W-1:0] lim;
      int                          phase;
      int                          budget;
      int                          target;
      int                          r;

      book = new();
      first_limits = '{7'd2, 7'd127, 7'd0, 7'd8, 7'd1, 7'd64, 7'd7};
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_rx_char    = 8'h00;
      rsp_stall      = 1'b0;
      csr_valid      = 1'b0;
      csr_line_limit = '0;
      stall_hold     = 0;
      items_sent     = 0;
      quiet_phase    = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, at the reset limit. Upper case folds to the word, and a line feed
      // is echoed as carriage return followed by line feed.
      send_text("RED");
      send_char(les_pkg::CHAR_LF);
      send_text("blue");
      send_char(les_pkg::CHAR_CR);
      // DEL on an empty line is only echoed.
      send_char(les_pkg::CHAR_DEL);
      // A typo erased by DEL still gives a match.
      send_text("cyz");
      send_char(les_pkg::CHAR_DEL);
      send_text("an");
      send_char(les_pkg::CHAR_LF);
      // A zero byte is stored like any other and never matches.
      send_char(8'h00);
      send_char(8'hFF);
      send_char(les_pkg::CHAR_CR);
      // Lowering the limit below the current fill ends the line on the next stored byte.
      send_text("abcde");
      write_limit(7'd4);
      send_char("x");

      // Random part: phases with different limits, the extremes first.
      target = items_sent + RANDOM_ITEMS;
      phase = 0;
      while (items_sent < target) begin
         if (phase < 7) begin
            lim = first_limits[phase];
         end else begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
               lim = 7'($urandom_range(7, 12));
            end else if (r == 6) begin
               lim = 7'($urandom_range(0, 6));
            end else if (r == 7) begin
               lim = 7'($urandom_range(13, 127));
            end else if (r == 8) begin
               lim = 7'd64;
            end else begin
               lim = 7'd127;
            end
         end
         write_limit(lim);
         quiet_phase = ($urandom_range(0, 3) == 0);
         budget = items_sent + $urandom_range(60, 150);
         while (items_sent < budget) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               send_keyword_line();
            end else if (r < 82) begin
               send_near_miss();
            end else begin
               send_noise();
            end
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (book.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (book.errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/les_pkg.sv
hw/rtl/les_ram.sv
hw/rtl/line_editor_keyword_led_select_unit.sv
hw/rtl/les_checker.sv
bench/tb.sv
